// File: rtl/lif_pkg.sv
// Shared constants, types and saturation helper for the LIF neuron update unit.
package lif_pkg;

    localparam int NEURONS_DEF = 256;
    localparam int IDX_W       = 8;
    localparam int POT_W       = 16;
    localparam int SHIFT_W     = 4;
    localparam int RSUB_W      = 15;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic signed [POT_W-1:0] POT_MIN = 16'sh8000;
    localparam logic signed [POT_W-1:0] POT_MAX = 16'sh7FFF;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_SHIFT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_SUBTRACT = 2'd2;

    localparam logic signed [POT_W-1:0] THRESHOLD_RST      = 16'sd16384;
    localparam logic [SHIFT_W-1:0]      DECAY_SHIFT_RST    = 4'd1;
    localparam logic [RSUB_W-1:0]       RESET_SUBTRACT_RST = 15'd16384;

    typedef struct packed {
        logic signed [POT_W-1:0] threshold;
        logic [SHIFT_W-1:0]      decay_shift;
        logic [RSUB_W-1:0]       reset_subtract;
    } cfg_t;

    // clamp a 17-bit signed value into int16
    function automatic logic signed [POT_W-1:0] sat16(input logic signed [POT_W:0] v);
        logic signed [POT_W-1:0] r;
        if (v < 17'sh1_8000)
        begin
            r = POT_MIN;
        end
        else if (v > 17'sh0_7FFF)
        begin
            r = POT_MAX;
        end
        else
        begin
            r = v[POT_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/lif_in_if.sv
// Input channel: neuron index and synaptic current with valid/ready.
interface lif_in_if;
    logic                                valid;
    logic                                ready;
    logic [lif_pkg::IDX_W-1:0]           neuron_index;
    logic signed [lif_pkg::POT_W-1:0]    input_current;

    modport source (output valid, output neuron_index, output input_current, input ready);
    modport sink   (input valid, input neuron_index, input input_current, output ready);
endinterface

// File: rtl/lif_out_if.sv
// Output channel: spike flag, index, new potential and scaled current.
interface lif_out_if;
    logic                                valid;
    logic                                ready;
    logic                                spike;
    logic [lif_pkg::IDX_W-1:0]           out_index;
    logic signed [lif_pkg::POT_W-1:0]    new_potential;
    logic signed [lif_pkg::POT_W-1:0]    scaled_current;

    modport source (output valid, output spike, output out_index, output new_potential,
                    output scaled_current, input ready);
    modport sink   (input valid, input spike, input out_index, input new_potential,
                    input scaled_current, output ready);
endinterface

// File: rtl/lif_mem.sv
// Membrane potential store: registered read data, per-entry valid bits cleared at reset.
module lif_mem #(
    parameter int DEPTH = lif_pkg::NEURONS_DEF,
    parameter int AW    = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             re,
    input  logic [AW-1:0]                    raddr,
    output logic signed [lif_pkg::POT_W-1:0] rdata,
    input  logic                             we,
    input  logic [AW-1:0]                    waddr,
    input  logic signed [lif_pkg::POT_W-1:0] wdata
);

    logic signed [lif_pkg::POT_W-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0]                 vld_reg;
    logic signed [lif_pkg::POT_W-1:0] rd_data_reg;
    logic                             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_vld_reg <= vld_reg[raddr];
            end
        end
    end

    // never-written entries read as the reset value of zero
    assign rdata = rd_vld_reg ? rd_data_reg : '0;

endmodule

// File: rtl/lif_calc.sv
// Neuron update datapath: threshold test, leak, spike reset and saturating integrate.
module lif_calc (
    input  lif_pkg::cfg_t                    cfg,
    input  logic signed [lif_pkg::POT_W-1:0] potential,
    input  logic signed [lif_pkg::POT_W-1:0] current,
    output logic                             spike,
    output logic signed [lif_pkg::POT_W-1:0] new_potential,
    output logic signed [lif_pkg::POT_W-1:0] scaled_current
);

    logic signed [lif_pkg::POT_W-1:0] leaked;
    logic signed [lif_pkg::POT_W:0]   reset_diff;
    logic signed [lif_pkg::POT_W-1:0] after_reset;
    logic signed [lif_pkg::POT_W:0]   doubled;
    logic signed [lif_pkg::POT_W:0]   total;

    always_comb
    begin
        spike       = potential > cfg.threshold;
        leaked      = potential >>> cfg.decay_shift;
        reset_diff  = {leaked[lif_pkg::POT_W-1], leaked}
                    - $signed({2'b00, cfg.reset_subtract});
        after_reset = spike ? lif_pkg::sat16(reset_diff) : leaked;
        doubled     = {current, 1'b0};
        scaled_current = lif_pkg::sat16(doubled);
        total       = {after_reset[lif_pkg::POT_W-1], after_reset}
                    + {scaled_current[lif_pkg::POT_W-1], scaled_current};
        new_potential = lif_pkg::sat16(total);
    end

endmodule

// File: rtl/lif_neuron_update_unit.sv
// LIF neuron update unit: config registers, read-modify-write pipeline, output register.
// Flow: an accepted input is registered in stage 1 with its memory read, then computed and written back.
// Throughput: one transaction per cycle, set by one read and one write of the potential store each
// cycle unless stalled; back-to-back same-neuron transactions take the written value by forwarding.
// Reset: potentials read as zero (per-entry valid bits cleared), registers take their reset values,
// pipeline empties; no clearing pass, inputs are taken right after reset.
module lif_neuron_update_unit #(
    parameter int NEURONS = lif_pkg::NEURONS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [lif_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lif_pkg::CFG_DATA_W-1:0]        cfg_data,
    lif_in_if.sink                                in_ch,
    lif_out_if.source                             out_ch
);

    // only indexes an 8-bit field can reach need storage
    localparam int DEPTH = (NEURONS < (1 << lif_pkg::IDX_W)) ? NEURONS : (1 << lif_pkg::IDX_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [16:0] NEURONS_W = 17'(NEURONS);

    lif_pkg::cfg_t cfg_reg;

    logic                             s1_valid_reg, s1_valid_next;
    logic [lif_pkg::IDX_W-1:0]        s1_index_reg;
    logic signed [lif_pkg::POT_W-1:0] s1_current_reg;
    logic                             s1_inside_reg;
    logic                             fwd_hit_reg;
    logic signed [lif_pkg::POT_W-1:0] fwd_data_reg;

    logic                             out_valid_reg, out_valid_next;
    logic                             out_spike_reg;
    logic [lif_pkg::IDX_W-1:0]        out_index_reg;
    logic signed [lif_pkg::POT_W-1:0] out_pot_reg;
    logic signed [lif_pkg::POT_W-1:0] out_scaled_reg;

    logic                             accept;
    logic                             in_inside;
    logic                             s1_adv;
    logic                             mem_we;
    logic                             fwd_hit_next;
    logic signed [lif_pkg::POT_W-1:0] rd_data;
    logic signed [lif_pkg::POT_W-1:0] s1_potential;
    logic                             calc_spike;
    logic signed [lif_pkg::POT_W-1:0] calc_pot;
    logic signed [lif_pkg::POT_W-1:0] calc_scaled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold      <= lif_pkg::THRESHOLD_RST;
            cfg_reg.decay_shift    <= lif_pkg::DECAY_SHIFT_RST;
            cfg_reg.reset_subtract <= lif_pkg::RESET_SUBTRACT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lif_pkg::REG_THRESHOLD:
                begin
                    cfg_reg.threshold <= $signed(cfg_data[lif_pkg::POT_W-1:0]);
                end
                lif_pkg::REG_DECAY_SHIFT:
                begin
                    cfg_reg.decay_shift <= cfg_data[lif_pkg::SHIFT_W-1:0];
                end
                lif_pkg::REG_RESET_SUBTRACT:
                begin
                    cfg_reg.reset_subtract <= cfg_data[lif_pkg::RSUB_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign s1_adv       = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !s1_valid_reg || s1_adv;
    assign accept       = in_ch.valid && in_ch.ready;
    assign in_inside    = {9'd0, in_ch.neuron_index} < NEURONS_W;
    assign mem_we       = s1_adv && s1_inside_reg;
    // the write leaving stage 1 lands on the same edge as the new read
    assign fwd_hit_next = mem_we && in_inside && (s1_index_reg == in_ch.neuron_index);

    assign s1_valid_next  = accept || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_index_reg   <= in_ch.neuron_index;
            s1_current_reg <= in_ch.input_current;
            s1_inside_reg  <= in_inside;
            fwd_hit_reg    <= fwd_hit_next;
            fwd_data_reg   <= calc_pot;
        end
        if (s1_adv)
        begin
            out_spike_reg  <= calc_spike;
            out_index_reg  <= s1_index_reg;
            out_pot_reg    <= calc_pot;
            out_scaled_reg <= calc_scaled;
        end
    end

    lif_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .re    (accept && in_inside),
        .raddr (in_ch.neuron_index[AW-1:0]),
        .rdata (rd_data),
        .we    (mem_we),
        .waddr (s1_index_reg[AW-1:0]),
        .wdata (calc_pot)
    );

    always_comb
    begin
        priority if (!s1_inside_reg)
        begin
            s1_potential = '0;
        end
        else if (fwd_hit_reg)
        begin
            s1_potential = fwd_data_reg;
        end
        else
        begin
            s1_potential = rd_data;
        end
    end

    lif_calc u_calc (
        .cfg            (cfg_reg),
        .potential      (s1_potential),
        .current        (s1_current_reg),
        .spike          (calc_spike),
        .new_potential  (calc_pot),
        .scaled_current (calc_scaled)
    );

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.spike          = out_spike_reg;
    assign out_ch.out_index      = out_index_reg;
    assign out_ch.new_potential  = out_pot_reg;
    assign out_ch.scaled_current = out_scaled_reg;

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (s1_valid_reg && out_valid_reg && !out_ch.ready))
        else $error("input stalled without a full pipeline");

    a_adv_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("stage 1 advanced but output register empty");

    a_write_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> s1_valid_reg)
        else $error("store written without an item in stage 1");

    a_fwd_on_match: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && fwd_hit_next) |=> (s1_valid_reg && fwd_hit_reg && s1_inside_reg))
        else $error("back-to-back same-neuron update missed forwarding");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_index_reg)))
        else $error("stalled stage 1 item changed");

endmodule

// File: dv/lif_neuron_update_unit_tb.sv
// Testbench for the LIF neuron update unit: directed and random traffic against a potential model.
`timescale 1ns / 1ps

module lif_neuron_update_unit_tb;

    localparam int QUIET_LIMIT = 2000;
    localparam int IDX_W       = lif_pkg::IDX_W;
    localparam int POT_W       = lif_pkg::POT_W;
    localparam int SHIFT_W     = lif_pkg::SHIFT_W;
    localparam int RSUB_W      = lif_pkg::RSUB_W;
    localparam int CFG_IDX_W   = lif_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = lif_pkg::CFG_DATA_W;

    typedef struct packed {
        logic                    spike;
        logic [IDX_W-1:0]        index;
        logic signed [POT_W-1:0] potential;
        logic signed [POT_W-1:0] current;
    } neuron_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lif_in_if  in_ch();
    lif_out_if out_ch();

    lif_neuron_update_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // local copy of the neuron state and register settings
    logic signed [POT_W-1:0] potential_mem [lif_pkg::NEURONS_DEF] = '{default: '0};
    logic signed [POT_W-1:0] thr_cfg;
    logic [SHIFT_W-1:0]      shift_cfg;
    logic [RSUB_W-1:0]       rsub_cfg;

    neuron_result_t expected_results[$];
    int error_count = 0;
    int quiet_cycles = 0;
    int stall_left = 0;
    bit source_gaps;
    bit sink_stalls;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int clamp16(input int v);
        if (v < -32768)
        begin
            return -32768;
        end
        if (v > 32767)
        begin
            return 32767;
        end
        return v;
    endfunction

    // leak, fire, reset and integrate one neuron; updates the local potential copy
    function automatic neuron_result_t integrate_neuron(input logic [IDX_W-1:0] idx,
                                                       input logic signed [POT_W-1:0] cur);
        neuron_result_t r;
        int pot;
        int scaled;
        pot = potential_mem[idx];
        r.spike = (pot > int'(thr_cfg));
        pot = pot >>> shift_cfg;
        if (r.spike)
        begin
            pot = clamp16(pot - int'(rsub_cfg));
        end
        scaled = clamp16(int'(cur) * 2);
        pot = clamp16(pot + scaled);
        potential_mem[idx] = pot[POT_W-1:0];
        r.index = idx;
        r.potential = pot[POT_W-1:0];
        r.current = scaled[POT_W-1:0];
        return r;
    endfunction

    // results are checked before the same edge's input is predicted
    always @(posedge clk)
    begin
        neuron_result_t got;
        neuron_result_t want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = {out_ch.spike, out_ch.out_index, out_ch.new_potential,
                       out_ch.scaled_current};
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("%0t: unexpected result spike=%0b idx=%0d pot=%0d cur=%0d",
                                 $realtime, got.spike, got.index, got.potential, got.current);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("%0t: mismatch exp spike=%0b idx=%0d pot=%0d cur=%0d",
                                     $realtime, want.spike, want.index, want.potential,
                                     want.current);
                            $display("%0t:          got spike=%0b idx=%0d pot=%0d cur=%0d",
                                     $realtime, got.spike, got.index, got.potential,
                                     got.current);
                        end
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                expected_results.push_back(integrate_neuron(in_ch.neuron_index,
                                                            in_ch.input_current));
            end
        end
    end

    // output backpressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if (sink_stalls && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 12) - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_current(input logic [IDX_W-1:0] idx, input logic signed [POT_W-1:0] cur);
        int gap;
        if (source_gaps && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.neuron_index <= idx;
        in_ch.input_current <= cur;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // only called with the pipeline empty; upper data bits are don't-care
    task automatic apply_settings(input logic signed [POT_W-1:0] thr,
                                  input logic [SHIFT_W-1:0] shift,
                                  input logic [RSUB_W-1:0] rsub);
        cfg_we <= 1'b1;
        cfg_index <= lif_pkg::REG_THRESHOLD;
        cfg_data <= thr;
        @(posedge clk);
        cfg_index <= lif_pkg::REG_DECAY_SHIFT;
        cfg_data <= {12'($urandom), shift};
        @(posedge clk);
        cfg_index <= lif_pkg::REG_RESET_SUBTRACT;
        cfg_data <= {1'($urandom), rsub};
        @(posedge clk);
        cfg_we <= 1'b0;
        thr_cfg = thr;
        shift_cfg = shift;
        rsub_cfg = rsub;
    endtask

    task automatic apply_random_settings();
        logic signed [POT_W-1:0] thr;
        logic [RSUB_W-1:0] rsub;
        case ($urandom_range(0, 5))
            0: thr = lif_pkg::POT_MIN;
            1: thr = lif_pkg::POT_MAX;
            2: thr = '0;
            3: thr = 16'($urandom);
            default: thr = 16'($urandom_range(0, 6000));
        endcase
        case ($urandom_range(0, 3))
            0: rsub = '0;
            1: rsub = '1;
            default: rsub = 15'($urandom);
        endcase
        apply_settings(thr, 4'($urandom_range(0, 15)), rsub);
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return IDX_W'($urandom_range(0, 7));
            4: return $urandom_range(0, 1) ? '1 : '0;
            default: return IDX_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [POT_W-1:0] pick_current();
        case ($urandom_range(0, 9))
            0: return lif_pkg::POT_MIN;
            1: return lif_pkg::POT_MAX;
            2: return POT_W'($urandom_range(0, 128)) - 16'sd64;
            3: return POT_W'(int'($urandom_range(16380, 16388))
                             * ($urandom_range(0, 1) ? 1 : -1));
            4, 5: return POT_W'($urandom_range(0, 8000));
            default: return POT_W'($urandom);
        endcase
    endfunction

    // reset register values: saturation of the doubled current, spike and reset, negative leak
    task automatic test_reset_defaults();
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        send_current(8'd0, lif_pkg::POT_MAX);
        send_current(8'd0, 16'sd0);
        send_current(8'd0, 16'sd0);
        send_current(8'd255, lif_pkg::POT_MIN);
        send_current(8'd255, -16'sd1);
        send_current(8'd1, 16'sd16384);
        send_current(8'd2, -16'sd16385);
        send_current(8'd3, 16'sd16383);
        send_current(8'd5, -16'sd1);
        send_current(8'd5, 16'sd0);
        send_current(8'd5, 16'sd0);
        send_current(8'd128, 16'sd8193);
        send_current(8'd128, 16'sd0);
    endtask

    task automatic test_config_extremes();
        wait_drained();
        apply_settings(lif_pkg::POT_MIN, 4'd0, 15'h7FFF);
        send_current(8'd10, lif_pkg::POT_MIN);
        send_current(8'd10, 16'sd0);
        send_current(8'd10, 16'sd1);
        send_current(8'd10, 16'sd0);
        wait_drained();
        apply_settings(lif_pkg::POT_MAX, 4'd15, 15'd0);
        send_current(8'd20, lif_pkg::POT_MAX);
        send_current(8'd20, 16'sd0);
        send_current(8'd21, lif_pkg::POT_MIN);
        send_current(8'd21, 16'sd0);
        send_current(8'd21, 16'sd0);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++)
        begin
            wait_drained();
            apply_random_settings();
            source_gaps = (phase != 2);
            sink_stalls = (phase != 3);
            repeat (250) send_current(pick_index(), pick_current());
        end
    endtask

    // no idling: same neuron back to back exercises the write-back forwarding
    task automatic test_back_to_back();
        wait_drained();
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        // let a stall burst already under way run out
        while (stall_left != 0) @(posedge clk);
        apply_settings(16'sd1000, 4'd2, 15'd3000);
        repeat (400)
        begin
            send_current($urandom_range(0, 1) ? IDX_W'($urandom_range(0, 3)) : pick_index(),
                         pick_current());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = lif_pkg::REG_THRESHOLD;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.neuron_index = '0;
        in_ch.input_current = '0;
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        thr_cfg = lif_pkg::THRESHOLD_RST;
        shift_cfg = lif_pkg::DECAY_SHIFT_RST;
        rsub_cfg = lif_pkg::RESET_SUBTRACT_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_config_extremes();
        test_random_traffic();
        test_back_to_back();

        wait_drained();
        if (error_count == 0 && expected_results.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/lif_pkg.sv
rtl/lif_in_if.sv
rtl/lif_out_if.sv
rtl/lif_mem.sv
rtl/lif_calc.sv
rtl/lif_neuron_update_unit.sv
dv/lif_neuron_update_unit_tb.sv
